/* rtl/core/oaht_pkg.sv */
// Shared types and constants for the open addressing hash table.
package oaht_pkg;

   localparam int KEY_W   = 31;
   localparam int COUNT_W = 7;
   localparam int SIZE_W  = 7;

   localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = 7'd64;

   // request codes
   localparam logic [1:0] OP_SEARCH = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_ERASE  = 2'd2;

   // slot status codes
   localparam logic [1:0] ST_EMPTY   = 2'd0;
   localparam logic [1:0] ST_LIVE    = 2'd1;
   localparam logic [1:0] ST_DELETED = 2'd2;

   typedef struct packed {
      logic [1:0]       req_type;
      logic [KEY_W-1:0] key;
   } req_word_type;

   typedef struct packed {
      logic               ok;
      logic [COUNT_W-1:0] live_count;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [KEY_W-1:0] key;
   } slot_word_type;

endpackage

/* rtl/core/open_addressing_hash_table.sv */
// Linear probing hash set: remainder unit, probe sequencer and slot memory.
//
//   channel | ports                                   | flow
//   --------+-----------------------------------------+---------------------------------
//   request | start, busy, req_word                   | taken when start & !busy
//   result  | rsp_strobe, rsp_word                    | one cycle per word, no back-pressure
//   config  | csr_valid, csr_ready, csr_table_size    | written when valid & ready
//
// Operation: a search, insert or erase first finds the home slot (key mod size, one key
// bit per cycle), then streams one slot read per cycle from the slot memory and strobes
// the result word after the last of the p slots checked, p <= effective size. Request
// code 3 and an insert into a full table answer straight from idle, with no divide or probe.
// Reset: synchronous; afterwards a clearing pass writes every slot empty, with busy high.
// A new request is taken in the cycle its predecessor's result is shown.
module open_addressing_hash_table #(
   parameter int CAPACITY = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  oaht_pkg::req_word_type        req_word,
   output logic                          rsp_strobe,
   output oaht_pkg::rsp_word_type        rsp_word,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [oaht_pkg::SIZE_W-1:0]   csr_table_size
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   // compare width that holds any index, any size and CAPACITY itself
   localparam int CW = ((IDX_W > oaht_pkg::SIZE_W) ? IDX_W : oaht_pkg::SIZE_W) + 1;
   localparam int SW = oaht_pkg::SIZE_W;

   typedef enum logic [3:0] {
      S_CLEAR  = 4'b0001,
      S_IDLE   = 4'b0010,
      S_DIVIDE = 4'b0100,
      S_PROBE  = 4'b1000
   } state_type;

   // control
   state_type                       state_ff, state_in;
   logic [IDX_W-1:0]                clr_idx_ff, clr_idx_in;
   logic [SW-1:0]                   table_size_ff, table_size_in;
   logic [oaht_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic                            rd_vld_ff, rd_vld_in;
   logic                            rsp_strobe_ff, rsp_strobe_in;

   // operation payload
   logic [1:0]                      op_ff, op_in;
   logic [oaht_pkg::KEY_W-1:0]      key_ff, key_in;
   logic [SW-1:0]                   size_ff, size_in;
   logic [4:0]                      bit_ff, bit_in;
   logic [SW-1:0]                   rem_ff, rem_in;
   logic [IDX_W-1:0]                iss_idx_ff, iss_idx_in;
   logic [SW-1:0]                   iss_cnt_ff, iss_cnt_in;
   logic [IDX_W-1:0]                rd_idx_ff, rd_idx_in;
   logic [SW-1:0]                   chk_cnt_ff, chk_cnt_in;
   logic                            free_vld_ff, free_vld_in;
   logic [IDX_W-1:0]                free_idx_ff, free_idx_in;
   logic                            rsp_ok_ff, rsp_ok_in;

   // slot memory
   oaht_pkg::slot_word_type         slot_mem [CAPACITY];
   oaht_pkg::slot_word_type         rd_data_ff;
   logic                            mem_we;
   logic [IDX_W-1:0]                mem_wa;
   oaht_pkg::slot_word_type         mem_wd;

   // combinational helpers
   logic [SW-1:0]                   eff_size;
   logic [SW:0]                     trial;
   logic [SW-1:0]                   rem_next;
   logic [CW-1:0]                   iss_plus;
   logic [IDX_W-1:0]                iss_wrap;
   logic                            is_live, is_empty, hit, last_chk, stop;
   logic                            fin_free_vld;
   logic [IDX_W-1:0]                fin_free_idx;

   assign busy       = (state_ff != S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = '{ok: rsp_ok_ff, live_count: count_ff};

   // table size clamped to 1..CAPACITY
   always_comb begin
      if (table_size_ff == '0) begin
         eff_size = SW'(1);
      end else if (CW'(table_size_ff) > CW'(CAPACITY)) begin
         eff_size = SW'(CAPACITY);
      end else begin
         eff_size = table_size_ff;
      end
   end

   // restoring remainder, one key bit per cycle
   assign trial    = {rem_ff, key_ff[bit_ff]};
   assign rem_next = (trial >= {1'b0, size_ff}) ? SW'(trial - {1'b0, size_ff})
                                                : trial[SW-1:0];

   // next probe address with wrap at the table size
   assign iss_plus = CW'(iss_idx_ff) + CW'(1);
   assign iss_wrap = (iss_plus >= CW'(size_ff)) ? '0 : iss_plus[IDX_W-1:0];

   // evaluation of the slot read last cycle
   assign is_live  = (rd_data_ff.status == oaht_pkg::ST_LIVE);
   assign is_empty = (rd_data_ff.status == oaht_pkg::ST_EMPTY);
   assign hit      = is_live && (rd_data_ff.key == key_ff);
   assign last_chk = ({1'b0, chk_cnt_ff} + (SW+1)'(1)) == {1'b0, size_ff};
   assign stop     = rd_vld_ff && (is_empty || hit || last_chk);

   // empty and deleted slots both count as free
   assign fin_free_vld = free_vld_ff || !is_live;
   assign fin_free_idx = free_vld_ff ? free_idx_ff : rd_idx_ff;

   always_comb begin
      state_in      = state_ff;
      clr_idx_in    = clr_idx_ff;
      table_size_in = table_size_ff;
      count_in      = count_ff;
      rd_vld_in     = 1'b0;
      rsp_strobe_in = 1'b0;
      op_in         = op_ff;
      key_in        = key_ff;
      size_in       = size_ff;
      bit_in        = bit_ff;
      rem_in        = rem_ff;
      iss_idx_in    = iss_idx_ff;
      iss_cnt_in    = iss_cnt_ff;
      rd_idx_in     = iss_idx_ff;
      chk_cnt_in    = chk_cnt_ff;
      free_vld_in   = free_vld_ff;
      free_idx_in   = free_idx_ff;
      rsp_ok_in     = rsp_ok_ff;
      mem_we        = 1'b0;
      mem_wa        = clr_idx_ff;
      mem_wd        = '{status: oaht_pkg::ST_EMPTY, key: '0};

      if (csr_valid) begin
         table_size_in = csr_table_size;
      end

      unique case (state_ff)
         S_CLEAR: begin
            mem_we     = 1'b1;
            clr_idx_in = clr_idx_ff + IDX_W'(1);
            if (clr_idx_ff == IDX_W'(CAPACITY - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               op_in   = req_word.req_type;
               key_in  = req_word.key;
               size_in = eff_size;
               bit_in  = 5'd30;
               rem_in  = '0;
               priority if (req_word.req_type != oaht_pkg::OP_SEARCH &&
                            req_word.req_type != oaht_pkg::OP_INSERT &&
                            req_word.req_type != oaht_pkg::OP_ERASE) begin
                  // unused code: answer at once
                  rsp_strobe_in = 1'b1;
                  rsp_ok_in     = 1'b0;
               end else if (req_word.req_type == oaht_pkg::OP_INSERT &&
                            count_ff >= eff_size) begin
                  // table full
                  rsp_strobe_in = 1'b1;
                  rsp_ok_in     = 1'b0;
               end else begin
                  state_in = S_DIVIDE;
               end
            end
         end
         S_DIVIDE: begin
            rem_in = rem_next;
            bit_in = bit_ff - 5'd1;
            if (bit_ff == 5'd0) begin
               state_in    = S_PROBE;
               iss_idx_in  = IDX_W'(rem_next);
               iss_cnt_in  = '0;
               chk_cnt_in  = '0;
               free_vld_in = 1'b0;
            end
         end
         S_PROBE: begin
            // issue side: one slot read per cycle ahead of the check
            if (iss_cnt_ff < size_ff && !stop) begin
               rd_vld_in  = 1'b1;
               iss_idx_in = iss_wrap;
               iss_cnt_in = iss_cnt_ff + SW'(1);
            end
            // check side
            if (rd_vld_ff) begin
               chk_cnt_in = chk_cnt_ff + SW'(1);
               if (!free_vld_ff && !is_live) begin
                  free_vld_in = 1'b1;
                  free_idx_in = rd_idx_ff;
               end
            end
            if (stop) begin
               state_in      = S_IDLE;
               rd_vld_in     = 1'b0;
               rsp_strobe_in = 1'b1;
               rsp_ok_in     = 1'b0;
               unique case (op_ff)
                  oaht_pkg::OP_SEARCH: begin
                     rsp_ok_in = hit;
                  end
                  oaht_pkg::OP_INSERT: begin
                     if (!hit && fin_free_vld) begin
                        mem_we    = 1'b1;
                        mem_wa    = fin_free_idx;
                        mem_wd    = '{status: oaht_pkg::ST_LIVE, key: key_ff};
                        count_in  = count_ff + oaht_pkg::COUNT_W'(1);
                        rsp_ok_in = 1'b1;
                     end
                  end
                  oaht_pkg::OP_ERASE: begin
                     if (hit) begin
                        mem_we    = 1'b1;
                        mem_wa    = rd_idx_ff;
                        mem_wd    = '{status: oaht_pkg::ST_DELETED, key: key_ff};
                        if (count_ff != '0) begin
                           count_in = count_ff - oaht_pkg::COUNT_W'(1);
                        end
                        rsp_ok_in = 1'b1;
                     end
                  end
                  default: begin
                     rsp_ok_in = 1'b0;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_idx_ff    <= '0;
         table_size_ff <= oaht_pkg::TABLE_SIZE_RESET;
         count_ff      <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_idx_ff    <= clr_idx_in;
         table_size_ff <= table_size_in;
         count_ff      <= count_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      size_ff     <= size_in;
      bit_ff      <= bit_in;
      rem_ff      <= rem_in;
      iss_idx_ff  <= iss_idx_in;
      iss_cnt_ff  <= iss_cnt_in;
      rd_idx_ff   <= rd_idx_in;
      chk_cnt_ff  <= chk_cnt_in;
      free_vld_ff <= free_vld_in;
      free_idx_ff <= free_idx_in;
      rsp_ok_ff   <= rsp_ok_in;
   end

   // slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= slot_mem[iss_idx_ff];
   end

endmodule
